/* rtl/core/vilt_pkg.sv */
// Package: payload types and register codes for the video line timer.
package vilt_pkg;
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [3:0] IDX_STATUS  = 4'd0;
	localparam logic [3:0] IDX_WIDTH   = 4'd2;
	localparam logic [3:0] IDX_VINTR   = 4'd3;
	localparam logic [3:0] IDX_CURRENT = 4'd4;
	localparam logic [3:0] IDX_VSYNC   = 4'd6;
	localparam logic [1:0] CFG_CLOCK   = 2'd0;
	localparam logic [1:0] CFG_REFRESH = 2'd1;
	localparam logic [25:0] CLOCK_RESET   = 26'd48681812;
	localparam logic [7:0]  REFRESH_RESET = 8'd60;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
		logic [31:0] write_mask;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        interrupt_pending;
		logic        frame_pulse;
		logic        status_changed;
		logic        width_changed;
	} out_item_t;
endpackage

/* rtl/core/video_interface_line_timer_regs.sv */
// Top level: video interface registers with scanline and frame timer.
// Ticks, reads and plain writes pass through S_RD (register file read) and S_EXEC to S_OUT.
// One item at a time, taken only in S_IDLE after the last result is accepted; a v_intr write also passes S_ARM,
// an unarmed read of current S_CUR_WB, an armed one a bit-serial line divide, a changing v_sync write two divides.
// The register file sits in a one-port synchronous memory with registered read.
// Reset: asynchronous; clears control and timer state; the register file is
// cleared by a sweep over all REG_COUNT entries after reset, no item taken meanwhile.
module video_interface_line_timer_regs
	import vilt_pkg::*;
#(
	parameter int REG_COUNT = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int AW = (REG_COUNT > 8) ? 4 : 3;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_EXEC, S_VS_RD, S_DIV1, S_DIV2, S_ARM_RD, S_ARM,
		S_CUR_VS, S_DIVL, S_CUR_WB, S_OUT
	} state_t;

	state_t state_q;
	logic [31:0] mem [REG_COUNT];
	logic [31:0] rdata_s1;
	logic        mem_we;
	logic [AW-1:0] mem_addr;
	logic [31:0] mem_wdata;

	logic [25:0] clock_q;
	logic [7:0]  refresh_q;
	in_item_t    item_q;
	out_item_t   res_q;
	logic        field_q, armed_q, irq_q;
	logic [31:0] period_q, tpl_q, tte_q;
	logic [31:0] status_q, vintr_q, vsync_q;
	logic [AW-1:0] clr_q;
	logic [32:0] num_q, quo_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic [31:0] line_q;

	logic [31:0] merged;
	logic        idx_ok;
	logic [33:0] rem_sh;
	logic [32:0] lines;
	logic [63:0] prod;

	assign idx_ok = ({1'b0, item_q.reg_index} < 5'(REG_COUNT));
	assign merged = (rdata_s1 & ~item_q.write_mask) | (item_q.write_data & item_q.write_mask);
	assign rem_sh = {rem_q, num_q[32]};
	assign lines  = {1'b0, vsync_q} + 33'd1;
	assign prod   = 64'(lines) * 64'(tpl_q);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cfg_ready = 1'b1;

	always_comb begin
		out_data = res_q;
		out_data.interrupt_pending = irq_q;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_addr = item_q.reg_index[AW-1:0];
		mem_wdata = merged;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: mem_addr = in_data.reg_index[AW-1:0];
			S_EXEC: begin
				mem_we = (item_q.operation == OP_WRITE) && idx_ok &&
					(item_q.reg_index != IDX_CURRENT) &&
					!(((item_q.reg_index == IDX_STATUS) || (item_q.reg_index == IDX_WIDTH) ||
					(item_q.reg_index == IDX_VSYNC)) &&
					((rdata_s1 & item_q.write_mask) == (item_q.write_data & item_q.write_mask)));
			end
			S_VS_RD, S_ARM_RD, S_CUR_VS: mem_addr = IDX_VSYNC[AW-1:0];
			S_CUR_WB: begin
				mem_we = 1'b1;
				mem_addr = IDX_CURRENT[AW-1:0];
				mem_wdata = {line_q[31:1], field_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rdata_s1 <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			clock_q <= CLOCK_RESET;
			refresh_q <= REFRESH_RESET;
			item_q <= '0;
			res_q <= '0;
			field_q <= 1'b0;
			armed_q <= 1'b0;
			irq_q <= 1'b0;
			period_q <= '0;
			tpl_q <= '0;
			tte_q <= '0;
			status_q <= '0;
			vintr_q <= '0;
			vsync_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			line_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_CLOCK)
					clock_q <= cfg_data[25:0];
				else if (cfg_index == CFG_REFRESH)
					refresh_q <= cfg_data[7:0];
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(REG_COUNT - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_EXEC;
				S_EXEC: begin
					res_q <= '0;
					state_q <= S_OUT;
					if (item_q.operation == OP_READ) begin
						if (item_q.reg_index == IDX_CURRENT && idx_ok) begin
							line_q <= rdata_s1;
							if (armed_q && tpl_q != 0) begin
								num_q <= {1'b0, period_q - tte_q};
								den_q <= {1'b0, tpl_q};
								rem_q <= '0;
								cnt_q <= '0;
								state_q <= S_DIVL;
							end else
								state_q <= S_CUR_WB;
						end else if (idx_ok)
							res_q.read_data <= rdata_s1;
					end else if (item_q.operation == OP_WRITE) begin
						if (item_q.reg_index == IDX_CURRENT)
							irq_q <= 1'b0;
						else if ((rdata_s1 & item_q.write_mask) !=
							(item_q.write_data & item_q.write_mask)) begin
							if (item_q.reg_index == IDX_STATUS) begin
								res_q.status_changed <= 1'b1;
								status_q <= merged;
							end
							if (item_q.reg_index == IDX_WIDTH)
								res_q.width_changed <= 1'b1;
							if (item_q.reg_index == IDX_VSYNC) begin
								vsync_q <= merged;
								num_q <= {7'd0, clock_q};
								den_q <= {25'd0, (refresh_q == 0) ? 8'd1 : refresh_q};
								rem_q <= '0;
								cnt_q <= '0;
								state_q <= S_DIV1;
							end
						end
						if (item_q.reg_index == IDX_VINTR) begin
							vintr_q <= merged;
							state_q <= S_ARM;
						end
					end else if (item_q.operation == OP_TICK && armed_q) begin
						if (tte_q == 0 || tte_q == 1) begin
							field_q <= field_q ^ status_q[6];
							res_q.frame_pulse <= 1'b1;
							irq_q <= 1'b1;
							if (period_q != 0)
								tte_q <= period_q;
							else begin
								tte_q <= '0;
								armed_q <= 1'b0;
							end
						end else
							tte_q <= tte_q - 1'b1;
					end
				end
				S_DIV1, S_DIV2, S_DIVL: begin
					num_q <= {num_q[31:0], 1'b0};
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= 33'(rem_sh - {1'b0, den_q});
						quo_q <= {quo_q[31:0], 1'b1};
					end else begin
						rem_q <= rem_sh[32:0];
						quo_q <= {quo_q[31:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd32) begin
						if (state_q == S_DIV1) begin
							num_q <= {(rem_sh >= {1'b0, den_q}) ?
								{quo_q[31:0], 1'b1} : {quo_q[31:0], 1'b0}};
							den_q <= lines;
							rem_q <= '0;
							cnt_q <= '0;
							state_q <= S_DIV2;
						end else if (state_q == S_DIV2) begin
							tpl_q <= (rem_sh >= {1'b0, den_q}) ?
								{quo_q[30:0], 1'b1} : {quo_q[30:0], 1'b0};
							state_q <= S_VS_RD;
						end else begin
							line_q <= (rem_sh >= {1'b0, den_q}) ?
								{quo_q[30:0], 1'b1} : {quo_q[30:0], 1'b0};
							state_q <= S_CUR_VS;
						end
					end
				end
				S_VS_RD: begin
					period_q <= prod[31:0];
					state_q <= S_ARM;
				end
				S_ARM: begin
					if (!armed_q && tpl_q != 0 && vintr_q < vsync_q) begin
						armed_q <= 1'b1;
						tte_q <= period_q;
					end
					state_q <= S_OUT;
				end
				S_CUR_VS: begin
					if (line_q >= vsync_q)
						line_q <= line_q - vsync_q;
					state_q <= S_CUR_WB;
				end
				S_CUR_WB: begin
					res_q.read_data <= {line_q[31:1], field_q};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready && !out_valid)
		else $error("transfer during clearing sweep");
endmodule
